// ===== design/cau_pkg.sv =====
// Shared types and constants for the complex arithmetic unit.
package cau_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int QUEUE_DEPTH   = 4;

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_DIV = 2'd3
    } cmd_t;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_OVF = 2'd1;
    localparam logic [1:0] ST_DZ  = 2'd2;

    typedef struct packed {
        cmd_t cmd;
        logic div_zero;
    } req_ctl_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

endpackage

// ===== design/cau_front.sv =====
// Front end: takes requests, flags divides by zero, feeds the queue.
module cau_front #(
    parameter int W = cau_pkg::WORD_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           command,
    input  logic signed [W-1:0]  a_re,
    input  logic signed [W-1:0]  a_im,
    input  logic signed [W-1:0]  b_re,
    input  logic signed [W-1:0]  b_im,
    input  cau_pkg::queue_stat_t q_stat,
    output logic                 push,
    output cau_pkg::req_ctl_t    push_ctl,
    output logic [4*W-1:0]       push_data
);
    import cau_pkg::*;

    logic          fr_v_reg, fr_v_next;
    req_ctl_t      ctl_reg;
    logic [4*W-1:0] data_reg;
    logic          load;
    req_ctl_t      ctl_next;

    assign in_stall = fr_v_reg && q_stat.full;
    assign load     = in_valid && !in_stall;
    assign push     = fr_v_reg && !q_stat.full;
    assign fr_v_next = load || (fr_v_reg && q_stat.full);

    always_comb
    begin
        ctl_next.cmd      = cmd_t'(command);
        ctl_next.div_zero = (cmd_t'(command) == CMD_DIV) && (b_re == '0) && (b_im == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fr_v_reg <= 1'b0;
        end
        else
        begin
            fr_v_reg <= fr_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ctl_reg  <= ctl_next;
            data_reg <= {a_re, a_im, b_re, b_im};
        end
    end

    assign push_ctl  = ctl_reg;
    assign push_data = data_reg;

endmodule

// ===== design/cau_queue.sv =====
// Short request queue between front end and datapath.
module cau_queue #(
    parameter int DW = 4 * cau_pkg::WORD_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  cau_pkg::req_ctl_t    push_ctl,
    input  logic [DW-1:0]        push_data,
    input  logic                 pop,
    output cau_pkg::req_ctl_t    pop_ctl,
    output logic [DW-1:0]        pop_data,
    output cau_pkg::queue_stat_t q_stat
);
    import cau_pkg::*;

    localparam int PB = $clog2(QUEUE_DEPTH);
    localparam int CB = $clog2(QUEUE_DEPTH + 1);

    req_ctl_t      ctl_q [QUEUE_DEPTH];
    logic [DW-1:0] dat_q [QUEUE_DEPTH];
    logic [PB-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CB-1:0] cnt_reg, cnt_next;
    logic          do_push, do_pop;

    assign q_stat.full  = (cnt_reg == CB'(QUEUE_DEPTH));
    assign q_stat.empty = (cnt_reg == '0);
    assign do_push = push && !q_stat.full;
    assign do_pop  = pop && !q_stat.empty;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CB'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CB'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PB'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PB'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            ctl_q[wr_ptr_reg] <= push_ctl;
            dat_q[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_ctl  = ctl_q[rd_ptr_reg];
    assign pop_data = dat_q[rd_ptr_reg];

`ifndef SYNTHESIS
    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CB'(QUEUE_DEPTH))
        else $error("queue count beyond depth");
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_stat.full)
        else $error("push into full queue");
    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> cnt_reg == $past(cnt_reg) + CB'(1))
        else $error("queue count did not advance");
`endif

endmodule

// ===== design/cau_back.sv =====
// Datapath: products, sums, restoring divider stages and saturation.
module cau_back #(
    parameter int W = cau_pkg::WORD_BITS_DEF,
    parameter int F = cau_pkg::FRAC_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cau_pkg::queue_stat_t q_stat,
    input  cau_pkg::req_ctl_t    pop_ctl,
    input  logic [4*W-1:0]       pop_data,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic signed [W-1:0]  res_re,
    output logic signed [W-1:0]  res_im,
    output logic [1:0]           status
);
    import cau_pkg::*;

    localparam int PW  = 2 * W;
    localparam int SW  = 2 * W + 1;
    localparam int CW  = 3 * W + F + 1;
    localparam int QB  = W + 1;
    localparam int NST = W + 2;
    localparam logic signed [SW-1:0] SMAX = (SW'(1) <<< (W - 1)) - SW'(1);
    localparam logic signed [SW-1:0] SMIN = -(SW'(1) <<< (W - 1));
    localparam logic signed [SW-1:0] BIAS = (SW'(1) <<< F) - SW'(1);
    localparam logic [QB-1:0] LIM_P = (QB'(1) << (W - 1)) - QB'(1);
    localparam logic [QB-1:0] LIM_N = QB'(1) << (W - 1);

    typedef struct packed {
        req_ctl_t               ctl;
        logic                   neg_re;
        logic                   neg_im;
        logic                   big_re;
        logic                   big_im;
        logic [CW-1:0]          rem_re;
        logic [CW-1:0]          rem_im;
        logic [QB-1:0]          q_re;
        logic [QB-1:0]          q_im;
        logic [PW-1:0]          den;
        logic signed [SW-1:0]   val_re;
        logic signed [SW-1:0]   val_im;
    } div_st_t;

    logic en;

    // stage 1: request
    logic                 s1_v_reg;
    req_ctl_t             s1_ctl_reg;
    logic signed [W-1:0]  s1_ar_reg, s1_ai_reg, s1_br_reg, s1_bi_reg;

    // stage 2: products
    logic                  s2_v_reg;
    req_ctl_t              s2_ctl_reg;
    logic signed [PW-1:0]  p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg, p_bb_r_reg, p_bb_i_reg;
    logic signed [SW-1:0]  s2_re_reg, s2_im_reg;
    logic signed [SW-1:0]  s2_re_next, s2_im_next;

    // stage 3: sums
    logic                  s3_v_reg;
    req_ctl_t              s3_ctl_reg;
    logic signed [SW-1:0]  s3_re_reg, s3_im_reg, s3_re_next, s3_im_next;
    logic [PW-1:0]         s3_den_reg;

    // divider stages
    logic    dv_reg [NST];
    div_st_t d_reg  [NST];
    div_st_t d_next [NST];

    logic                 out_v_reg;
    logic signed [W-1:0]  res_re_reg, res_im_reg, res_re_next, res_im_next;
    logic [1:0]           status_reg, status_next;

    assign en  = !out_v_reg || !out_stall;
    assign pop = en && !q_stat.empty;

    always_comb
    begin
        if (s1_ctl_reg.cmd == CMD_ADD)
        begin
            s2_re_next = SW'(s1_ar_reg) + SW'(s1_br_reg);
            s2_im_next = SW'(s1_ai_reg) + SW'(s1_bi_reg);
        end
        else
        begin
            s2_re_next = SW'(s1_ar_reg) - SW'(s1_br_reg);
            s2_im_next = SW'(s1_ai_reg) - SW'(s1_bi_reg);
        end
    end

    always_comb
    begin
        case (s2_ctl_reg.cmd)
            CMD_MUL:
            begin
                s3_re_next = SW'(p_rr_reg) - SW'(p_ii_reg);
                s3_im_next = SW'(p_ri_reg) + SW'(p_ir_reg);
            end
            CMD_DIV:
            begin
                s3_re_next = SW'(p_rr_reg) + SW'(p_ii_reg);
                s3_im_next = SW'(p_ir_reg) - SW'(p_ri_reg);
            end
            default:
            begin
                s3_re_next = s2_re_reg;
                s3_im_next = s2_im_reg;
            end
        endcase
    end

    // prep: truncating shift for multiply, magnitudes and range check for divide
    always_comb
    begin
        logic [SW-1:0] mag_re, mag_im;
        d_next[0].ctl    = s3_ctl_reg;
        d_next[0].neg_re = s3_re_reg[SW-1];
        d_next[0].neg_im = s3_im_reg[SW-1];
        d_next[0].den    = s3_den_reg;
        d_next[0].q_re   = '0;
        d_next[0].q_im   = '0;
        mag_re = s3_re_reg[SW-1] ? -s3_re_reg : s3_re_reg;
        mag_im = s3_im_reg[SW-1] ? -s3_im_reg : s3_im_reg;
        d_next[0].rem_re = CW'(mag_re[PW-1:0]) << F;
        d_next[0].rem_im = CW'(mag_im[PW-1:0]) << F;
        d_next[0].big_re = d_next[0].rem_re >= (CW'(s3_den_reg) << QB);
        d_next[0].big_im = d_next[0].rem_im >= (CW'(s3_den_reg) << QB);
        if (s3_ctl_reg.cmd == CMD_MUL)
        begin
            d_next[0].val_re = s3_re_reg[SW-1] ? (s3_re_reg + BIAS) >>> F : s3_re_reg >>> F;
            d_next[0].val_im = s3_im_reg[SW-1] ? (s3_im_reg + BIAS) >>> F : s3_im_reg >>> F;
        end
        else
        begin
            d_next[0].val_re = s3_re_reg;
            d_next[0].val_im = s3_im_reg;
        end
    end

    for (genvar k = 0; k < QB; k++)
    begin : g_div
        localparam int SH = W - k;
        always_comb
        begin
            logic [CW-1:0] t;
            d_next[k+1] = d_reg[k];
            t = CW'(d_reg[k].den) << SH;
            if (d_reg[k].rem_re >= t)
            begin
                d_next[k+1].rem_re   = d_reg[k].rem_re - t;
                d_next[k+1].q_re[SH] = 1'b1;
            end
            if (d_reg[k].rem_im >= t)
            begin
                d_next[k+1].rem_im   = d_reg[k].rem_im - t;
                d_next[k+1].q_im[SH] = 1'b1;
            end
        end
    end

    for (genvar k = 0; k < NST; k++)
    begin : g_stage
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                if (k == 0)
                begin
                    dv_reg[k] <= s3_v_reg;
                end
                else
                begin
                    dv_reg[k] <= dv_reg[(k == 0) ? 0 : k - 1];
                end
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                d_reg[k] <= d_next[k];
            end
        end
    end

    // saturation
    always_comb
    begin
        div_st_t       f;
        logic          ov_re, ov_im;
        logic [QB-1:0] mr, mi;
        f = d_reg[NST-1];
        ov_re = 1'b0;
        ov_im = 1'b0;
        mr = f.q_re;
        mi = f.q_im;
        res_re_next = f.val_re[W-1:0];
        res_im_next = f.val_im[W-1:0];
        if (f.ctl.cmd == CMD_DIV)
        begin
            if (f.big_re || mr > (f.neg_re ? LIM_N : LIM_P))
            begin
                mr = f.neg_re ? LIM_N : LIM_P;
                ov_re = 1'b1;
            end
            if (f.big_im || mi > (f.neg_im ? LIM_N : LIM_P))
            begin
                mi = f.neg_im ? LIM_N : LIM_P;
                ov_im = 1'b1;
            end
            res_re_next = f.neg_re ? -mr[W-1:0] : mr[W-1:0];
            res_im_next = f.neg_im ? -mi[W-1:0] : mi[W-1:0];
        end
        else
        begin
            if (f.val_re > SMAX)
            begin
                res_re_next = SMAX[W-1:0];
                ov_re = 1'b1;
            end
            else if (f.val_re < SMIN)
            begin
                res_re_next = SMIN[W-1:0];
                ov_re = 1'b1;
            end
            if (f.val_im > SMAX)
            begin
                res_im_next = SMAX[W-1:0];
                ov_im = 1'b1;
            end
            else if (f.val_im < SMIN)
            begin
                res_im_next = SMIN[W-1:0];
                ov_im = 1'b1;
            end
        end
        status_next = (ov_re || ov_im) ? ST_OVF : ST_OK;
        if (f.ctl.div_zero)
        begin
            res_re_next = '0;
            res_im_next = '0;
            status_next = ST_DZ;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg  <= !q_stat.empty;
            s2_v_reg  <= s1_v_reg;
            s3_v_reg  <= s2_v_reg;
            out_v_reg <= dv_reg[NST-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_ctl_reg <= pop_ctl;
            s1_ar_reg  <= pop_data[4*W-1:3*W];
            s1_ai_reg  <= pop_data[3*W-1:2*W];
            s1_br_reg  <= pop_data[2*W-1:W];
            s1_bi_reg  <= pop_data[W-1:0];
            s2_ctl_reg <= s1_ctl_reg;
            p_rr_reg   <= PW'(s1_ar_reg) * PW'(s1_br_reg);
            p_ii_reg   <= PW'(s1_ai_reg) * PW'(s1_bi_reg);
            p_ri_reg   <= PW'(s1_ar_reg) * PW'(s1_bi_reg);
            p_ir_reg   <= PW'(s1_ai_reg) * PW'(s1_br_reg);
            p_bb_r_reg <= PW'(s1_br_reg) * PW'(s1_br_reg);
            p_bb_i_reg <= PW'(s1_bi_reg) * PW'(s1_bi_reg);
            s2_re_reg  <= s2_re_next;
            s2_im_reg  <= s2_im_next;
            s3_ctl_reg <= s2_ctl_reg;
            s3_re_reg  <= s3_re_next;
            s3_im_reg  <= s3_im_next;
            s3_den_reg <= $unsigned(p_bb_r_reg) + $unsigned(p_bb_i_reg);
            res_re_reg <= res_re_next;
            res_im_reg <= res_im_next;
            status_reg <= status_next;
        end
    end

    assign out_valid = out_v_reg;
    assign res_re    = res_re_reg;
    assign res_im    = res_im_reg;
    assign status    = status_reg;

`ifndef SYNTHESIS
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_OK || status == ST_OVF || status == ST_DZ))
        else $error("undefined status code");
    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_DZ) |-> (res_re == '0 && res_im == '0))
        else $error("divide by zero with nonzero result");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(dv_reg[NST-1]) && $stable(s1_v_reg))
        else $error("pipeline moved while output stalled");
`endif

endmodule

// ===== design/complex_arith_unit.sv =====
// Complex arithmetic unit top level: front end, request queue and datapath.
//
// Takes one request per cycle while in_stall is low (add, subtract, multiply
// or divide of two signed fixed-point complex numbers) and returns one
// result per request in order. The pipeline length is set by the restoring
// divider, one quotient bit per pipeline stage, which every command passes
// through. While out_stall is high and a result is waiting, the datapath
// holds and the four-entry queue fills before in_stall rises.
module complex_arith_unit #(
    parameter int WORD_BITS = cau_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   command,
    input  logic signed [WORD_BITS-1:0]  a_re,
    input  logic signed [WORD_BITS-1:0]  a_im,
    input  logic signed [WORD_BITS-1:0]  b_re,
    input  logic signed [WORD_BITS-1:0]  b_im,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [WORD_BITS-1:0]  res_re,
    output logic signed [WORD_BITS-1:0]  res_im,
    output logic [1:0]                   status
);
    import cau_pkg::*;

    queue_stat_t            q_stat;
    logic                   push, pop;
    req_ctl_t               push_ctl, pop_ctl;
    logic [4*WORD_BITS-1:0] push_data, pop_data;

    cau_front #(.W(WORD_BITS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .a_re      (a_re),
        .a_im      (a_im),
        .b_re      (b_re),
        .b_im      (b_im),
        .q_stat    (q_stat),
        .push      (push),
        .push_ctl  (push_ctl),
        .push_data (push_data)
    );

    cau_queue #(.DW(4 * WORD_BITS)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_ctl  (push_ctl),
        .push_data (push_data),
        .pop       (pop),
        .pop_ctl   (pop_ctl),
        .pop_data  (pop_data),
        .q_stat    (q_stat)
    );

    cau_back #(.W(WORD_BITS), .F(FRAC_BITS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .pop_ctl   (pop_ctl),
        .pop_data  (pop_data),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res_re    (res_re),
        .res_im    (res_im),
        .status    (status)
    );

endmodule

// ===== tb/sv/complex_arith_unit_tb.sv =====
// Self-checking testbench for the complex arithmetic unit, with random handshake idling.
module complex_arith_unit_tb;
    import cau_pkg::*;

    typedef struct {
        logic signed [31:0] re;
        logic signed [31:0] im;
        logic [1:0]         st;
    } cplx_result_t;

    class cplx_scoreboard;
        cplx_result_t pending_results[$];
        int           errors;

        function automatic logic [31:0] clamp(logic signed [127:0] v, ref bit ovf);
            logic [127:0] mag;
            logic [127:0] lim;
            logic         neg;
            neg = v < 0;
            mag = neg ? -v : v;
            lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
            if (mag > lim)
            begin
                mag = lim;
                ovf = 1'b1;
            end
            return neg ? 32'(-mag) : 32'(mag);
        endfunction

        function automatic logic signed [127:0] shr_trunc(logic signed [127:0] v);
            logic [127:0] mag;
            mag = (v < 0) ? -v : v;
            mag = mag >> 16;
            return (v < 0) ? -$signed(mag) : $signed(mag);
        endfunction

        function automatic logic signed [127:0] div_frac(logic signed [127:0] n,
                                                        logic signed [127:0] den);
            logic [127:0] mag;
            mag = (n < 0) ? -n : n;
            mag = (mag << 16) / den;
            return (n < 0) ? -$signed(mag) : $signed(mag);
        endfunction

        function void note(cmd_t cmd, logic signed [31:0] ar, logic signed [31:0] ai,
                           logic signed [31:0] br, logic signed [31:0] bi);
            logic signed [127:0] xr, xi, yr, yi, rr, ri, den;
            cplx_result_t        r;
            bit                  ovf;
            xr = ar; xi = ai; yr = br; yi = bi;
            ovf = 0;
            case (cmd)
                CMD_ADD:
                begin
                    rr = xr + yr;
                    ri = xi + yi;
                end
                CMD_SUB:
                begin
                    rr = xr - yr;
                    ri = xi - yi;
                end
                CMD_MUL:
                begin
                    rr = shr_trunc(xr * yr - xi * yi);
                    ri = shr_trunc(xr * yi + xi * yr);
                end
                default:
                begin
                    den = yr * yr + yi * yi;
                    if (den == 0)
                    begin
                        r.re = '0;
                        r.im = '0;
                        r.st = ST_DZ;
                        pending_results.push_back(r);
                        return;
                    end
                    rr = div_frac(xr * yr + xi * yi, den);
                    ri = div_frac(xi * yr - xr * yi, den);
                end
            endcase
            r.re = clamp(rr, ovf);
            r.im = clamp(ri, ovf);
            r.st = ovf ? ST_OVF : ST_OK;
            pending_results.push_back(r);
        endfunction

        function void check(logic signed [31:0] re, logic signed [31:0] im, logic [1:0] st);
            cplx_result_t e;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result re=%h im=%h status=%0d", $time, re, im, st);
                errors++;
                return;
            end
            e = pending_results.pop_front();
            if (re !== e.re)
            begin
                $display("%0t: res_re expected %h actual %h", $time, e.re, re);
                errors++;
            end
            if (im !== e.im)
            begin
                $display("%0t: res_im expected %h actual %h", $time, e.im, im);
                errors++;
            end
            if (st !== e.st)
            begin
                $display("%0t: status expected %0d actual %0d", $time, e.st, st);
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         command;
    logic signed [31:0] a_re, a_im, b_re, b_im;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [31:0] res_re, res_im;
    logic [1:0]         status;

    cplx_scoreboard sb = new();
    bit             quiet;
    int             stall_left = 0;

    complex_arith_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .a_re      (a_re),
        .a_im      (a_im),
        .b_re      (b_re),
        .b_im      (b_im),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res_re    (res_re),
        .res_im    (res_im),
        .status    (status)
    );

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(12 * 400000);
        $display("complex_arith_unit_tb: errors");
        $finish;
    end

    function automatic logic signed [31:0] pick_operand();
        case ($urandom_range(0, 5))
            0:       return $urandom();
            1:       return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
            2:       return 32'($signed($urandom_range(0, 1 << 25)) - (1 << 24));
            3:       return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
            4:       return $urandom_range(0, 1) ? 32'sh0001_0000 : -32'sh0001_0000;
            default: return $urandom_range(0, 1) ? 32'sd0 : 32'(32'sd1 <<< $urandom_range(0, 31));
        endcase
    endfunction

    task automatic send_request(cmd_t cmd, logic signed [31:0] ar, logic signed [31:0] ai,
                                logic signed [31:0] br, logic signed [31:0] bi);
        int gap;
        gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        a_re     <= ar;
        a_im     <= ai;
        b_re     <= br;
        b_im     <= bi;
        do
            @(posedge clk);
        while (in_stall);
        sb.note(cmd, ar, ai, br, bi);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check(res_re, res_im, status);
        if (stall_left > 0)
            stall_left <= stall_left - 1;
        else if (!quiet && $urandom_range(0, 5) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 13);
        end
        else
            out_stall <= 1'b0;
    end

    initial
    begin
        logic signed [31:0] mx, mn;
        int                 waited;
        mx = 32'sh7fff_ffff;
        mn = 32'sh8000_0000;
        rst_n      = 0;
        in_valid   = 0;
        quiet      = 0;
        command    = CMD_ADD;
        a_re = 0; a_im = 0; b_re = 0; b_im = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(CMD_ADD, 32'sh0001_8000, -32'sh0000_4000, 32'sh0002_0000, 32'sh0000_4000);
        send_request(CMD_ADD, mx, mn, mx, mn);
        send_request(CMD_ADD, mx, mn, 1, -1);
        send_request(CMD_SUB, mn, mx, 1, -1);
        send_request(CMD_SUB, 0, 0, mn, mn);
        send_request(CMD_SUB, 32'sh0003_0000, 32'sh0000_1000, 32'sh0001_0000, 32'sh0000_2000);
        send_request(CMD_MUL, 32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, -32'sh0001_0000);
        send_request(CMD_MUL, mn, mn, mn, mn);
        send_request(CMD_MUL, mx, mx, mx, mn);
        send_request(CMD_MUL, -1, 1, 1, 1);
        send_request(CMD_MUL, -32'sd3, 32'sd5, 32'sh0000_8000, 32'sd7);
        send_request(CMD_DIV, 32'sh0001_0000, 0, 0, 0);
        send_request(CMD_DIV, mx, mn, 0, 0);
        send_request(CMD_DIV, 32'sh0004_0000, 32'sh0002_0000, 32'sh0001_0000, 32'sh0001_0000);
        send_request(CMD_DIV, mx, mx, 1, 0);
        send_request(CMD_DIV, mn, mn, mn, mn);
        send_request(CMD_DIV, 1, -1, mx, mn);
        send_request(CMD_DIV, -32'sh0005_0000, 32'sh0000_0003, 0, -32'sh0002_0000);
        send_request(CMD_DIV, 0, 0, mn, 0);

        for (int n = 0; n < 450; n++)
        begin
            if (n >= 390)
                quiet = 1;
            send_request(cmd_t'($urandom_range(0, 3)), pick_operand(), pick_operand(),
                         pick_operand(), pick_operand());
        end
        in_valid <= 1'b0;

        waited = 0;
        while (sb.pending_results.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (60) @(posedge clk);
        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("complex_arith_unit_tb: clean");
        else
            $display("complex_arith_unit_tb: errors");
        $finish;
    end
endmodule
